// ----- hdl/hybrid_branch_predictor_macros.svh -----
// Assertion helpers for the predictor RTL.
`ifndef HYBRID_BRANCH_PREDICTOR_MACROS_SVH
`define HYBRID_BRANCH_PREDICTOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define HBP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define HBP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/hbp_pkg.sv -----
`default_nettype none
package hbp_pkg;

	localparam int PC_W    = 24;
	localparam int CTR_W   = 3;
	localparam int CHO_W   = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 4;
	localparam int CNT_W   = 32;

	localparam logic [CTR_W-1:0] CTR_INIT  = 3'd4;
	localparam logic [CTR_W-1:0] CTR_MAX   = 3'd7;
	localparam logic [CTR_W-1:0] CTR_TAKEN = 3'd4;
	localparam logic [CHO_W-1:0] CHO_INIT   = 2'd1;
	localparam logic [CHO_W-1:0] CHO_MAX    = 2'd3;
	localparam logic [CHO_W-1:0] CHO_GSHARE = 2'd2;

	// prediction modes; the unused code behaves as hybrid
	localparam logic [1:0] MODE_BIMODAL = 2'd0;
	localparam logic [1:0] MODE_GSHARE  = 2'd1;
	localparam logic [1:0] MODE_HYBRID  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIM_BITS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GSH_BITS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HIST_LEN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CHO_BITS = 3'd4;

	localparam logic [CFG_DATA_W-1:0] RST_INDEX_BITS = 4'd14;
	localparam logic [CFG_DATA_W-1:0] RST_HIST_LEN   = 4'd8;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic [PC_W-1:0] pc;
		logic            taken;
	} branch_t;

	typedef struct packed {
		logic             predicted_taken;
		logic             mispredict;
		logic             used_gshare;
		logic [CNT_W-1:0] mispredict_count;
	} result_t;

	// training decision from the update unit
	typedef struct packed {
		logic             pred;
		logic             miss;
		logic             use_g;
		logic             bim_we;
		logic             gsh_we;
		logic             cho_we;
		logic [CTR_W-1:0] bim_new;
		logic [CTR_W-1:0] gsh_new;
		logic [CHO_W-1:0] cho_new;
	} upd_t;

endpackage
`default_nettype wire

// ----- hdl/hybrid_branch_predictor.sv -----
`default_nettype none
// Bimodal / gshare hybrid branch predictor. Each item is one branch (byte PC and
// actual direction); the block predicts from 3-bit saturating counters, trains
// only the counter that supplied the prediction, moves the 2-bit chooser in hybrid
// mode, shifts the global history and returns prediction, mispredict flag, the
// predictor used and a running 32-bit mispredict count. Timing: after reset the
// three counter tables are swept to their reset values, one entry per cycle over all
// 2**MAX_INDEX_BITS entries, with busy high (config writes are still taken). After
// that an item is accepted on start while busy is low; the tables are read on the
// accept edge, trained and written back on the next edge, and the result is on
// the result port with done high for a single cycle from that edge. The table RAMs
// have a registered read ahead of the write-back; busy is low again in the cycle
// done is shown, so a new item can follow then. The result cannot be stalled:
// sample it whenever done is high. Configure only while no item is in flight;
// cfg_ready is always high.
module hybrid_branch_predictor
	import hbp_pkg::*;
#(
	parameter int MAX_INDEX_BITS = 14,
	parameter int PC_WORD_BITS   = 22
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire branch_t               branch,
	output logic                       done,
	output result_t                    result,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

`include "hybrid_branch_predictor_macros.svh"

	localparam int IW    = MAX_INDEX_BITS;
	localparam int DEPTH = 1 << IW;
	localparam int CW    = $clog2(MAX_INDEX_BITS + 1);
	localparam int WW    = (PC_WORD_BITS > PC_W - 2) ? PC_WORD_BITS : PC_W - 2;
	localparam logic [WW-1:0] WMASK = {WW{1'b1}} >> (WW - PC_WORD_BITS);

	// clamp a 4-bit width register into 0/1 .. MAX_INDEX_BITS
	function automatic logic [CW-1:0] clamp_bits(input logic [CFG_DATA_W-1:0] b,
		input logic lo_one);
		logic [CW-1:0] r;
		if (lo_one && b == '0) r = CW'(1);
		else if (int'(b) > MAX_INDEX_BITS) r = CW'(MAX_INDEX_BITS);
		else r = CW'(b);
		return r;
	endfunction

	function automatic logic [IW-1:0] low_mask(input logic [CW-1:0] b);
		logic [IW-1:0] m;
		for (int i = 0; i < IW; i++) m[i] = (i < int'(b));
		return m;
	endfunction

	// configuration registers
	logic [1:0]            mode_q;
	logic [CFG_DATA_W-1:0] bim_bits_q, gsh_bits_q, hist_len_q, cho_bits_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_HYBRID;
			bim_bits_q <= RST_INDEX_BITS;
			gsh_bits_q <= RST_INDEX_BITS;
			hist_len_q <= RST_HIST_LEN;
			cho_bits_q <= RST_INDEX_BITS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE:     mode_q     <= cfg_data[1:0];
				REG_BIM_BITS: bim_bits_q <= cfg_data;
				REG_GSH_BITS: gsh_bits_q <= cfg_data;
				REG_HIST_LEN: hist_len_q <= cfg_data;
				REG_CHO_BITS: cho_bits_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// control
	state_t        state_q, state_d;
	logic [IW-1:0] clr_q;
	logic          accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == {IW{1'b1}}) state_d = ST_IDLE;
			ST_IDLE:  if (start) state_d = ST_EXEC;
			ST_EXEC:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// index generation on the accept cycle
	logic [IW-1:0] hist_q, hist_m, hist_d;
	logic [IW-1:0] word_ix, bmask, gmask, cmask, hmask;
	logic [IW-1:0] bi, gi, ci;
	logic [CW-1:0] hlen;
	logic [WW-1:0] word_full;

	always_comb begin
		word_full = WW'(branch.pc[PC_W-1:2]) & WMASK;
		word_ix   = word_full[IW-1:0];
		bmask     = low_mask(clamp_bits(bim_bits_q, 1'b1));
		gmask     = low_mask(clamp_bits(gsh_bits_q, 1'b1));
		cmask     = low_mask(clamp_bits(cho_bits_q, 1'b1));
		hlen      = clamp_bits(hist_len_q, 1'b0);
		hmask     = low_mask(hlen);
		hist_m    = hist_q & hmask;
		bi        = word_ix & bmask;
		gi        = (word_ix ^ hist_m) & gmask;
		ci        = word_ix & cmask;
		// new outcome enters at the top of the live history
		hist_d    = hist_m >> 1;
		for (int i = 0; i < IW; i++)
			if (i + 1 == int'(hlen)) hist_d[i] = branch.taken;
		hist_d    = hist_d & hmask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) hist_q <= '0;
		else if (accept) hist_q <= hist_d;
	end

	logic [IW-1:0] bi_s1, gi_s1, ci_s1;
	logic          taken_s1;
	logic [1:0]    mode_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			bi_s1    <= bi;
			gi_s1    <= gi;
			ci_s1    <= ci;
			taken_s1 <= branch.taken;
			mode_s1  <= mode_q;
		end
	end

	// counter tables: read on accept, written back in the exec cycle or by the sweep
	logic [CTR_W-1:0] bim_mem [DEPTH];
	logic [CTR_W-1:0] gsh_mem [DEPTH];
	logic [CHO_W-1:0] cho_mem [DEPTH];
	logic [CTR_W-1:0] bim_rd_q, gsh_rd_q;
	logic [CHO_W-1:0] cho_rd_q;
	upd_t             upd;
	logic             clearing, exec;

	assign clearing = (state_q == ST_CLEAR);
	assign exec     = (state_q == ST_EXEC);

	hbp_update u_update (
		.bim_ctr (bim_rd_q),
		.gsh_ctr (gsh_rd_q),
		.cho_ctr (cho_rd_q),
		.taken   (taken_s1),
		.mode    (mode_s1),
		.upd     (upd)
	);

	always_ff @(posedge clk) begin
		if (clearing) bim_mem[clr_q] <= CTR_INIT;
		else if (exec && upd.bim_we) bim_mem[bi_s1] <= upd.bim_new;
		if (accept) bim_rd_q <= bim_mem[bi];
	end

	always_ff @(posedge clk) begin
		if (clearing) gsh_mem[clr_q] <= CTR_INIT;
		else if (exec && upd.gsh_we) gsh_mem[gi_s1] <= upd.gsh_new;
		if (accept) gsh_rd_q <= gsh_mem[gi];
	end

	always_ff @(posedge clk) begin
		if (clearing) cho_mem[clr_q] <= CHO_INIT;
		else if (exec && upd.cho_we) cho_mem[ci_s1] <= upd.cho_new;
		if (accept) cho_rd_q <= cho_mem[ci];
	end

	// miss total and result register
	logic [CNT_W-1:0] miss_q, miss_d;

	assign miss_d = miss_q + CNT_W'(upd.miss);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= exec;
			if (exec) miss_q <= miss_d;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			result.predicted_taken  <= upd.pred;
			result.mispredict       <= upd.miss;
			result.used_gshare      <= upd.use_g;
			result.mispredict_count <= miss_d;
		end
	end

	`HBP_ASSERT_NEXT(a_exec_gives_done, exec, done && !busy, "exec did not yield one result")
	`HBP_ASSERT_NOW(a_done_after_exec, done, $past(exec), "result strobe without exec")
	`HBP_ASSERT_NOW(a_one_table_trained, exec, !(upd.bim_we && upd.gsh_we),
		"both counter tables trained")
	`HBP_ASSERT_NEXT(a_miss_count, exec,
		miss_q == $past(miss_q) + CNT_W'($past(upd.miss)), "miss total out of step")
	`HBP_ASSERT_NOW(a_count_matches, done, result.mispredict_count == miss_q,
		"reported count differs from total")

endmodule
`default_nettype wire

// ----- hdl/hbp_update.sv -----
`default_nettype none
module hbp_update
	import hbp_pkg::*;
(
	input  wire logic [CTR_W-1:0] bim_ctr,
	input  wire logic [CTR_W-1:0] gsh_ctr,
	input  wire logic [CHO_W-1:0] cho_ctr,
	input  wire logic             taken,
	input  wire logic [1:0]       mode,
	output upd_t                  upd
);

	function automatic logic [CTR_W-1:0] train3(input logic [CTR_W-1:0] c, input logic t);
		logic [CTR_W-1:0] r;
		r = c;
		if (t) begin
			if (c < CTR_MAX) r = c + 1'b1;
		end else begin
			if (c != '0) r = c - 1'b1;
		end
		return r;
	endfunction

	logic pb, pg, use_g, hybrid, bok, gok;

	always_comb begin
		pb     = (bim_ctr >= CTR_TAKEN);
		pg     = (gsh_ctr >= CTR_TAKEN);
		hybrid = (mode != MODE_BIMODAL) && (mode != MODE_GSHARE);
		if (mode == MODE_BIMODAL) use_g = 1'b0;
		else if (mode == MODE_GSHARE) use_g = 1'b1;
		else use_g = (cho_ctr >= CHO_GSHARE);
		bok = (pb == taken);
		gok = (pg == taken);

		upd.use_g   = use_g;
		upd.pred    = use_g ? pg : pb;
		upd.miss    = upd.pred != taken;
		upd.bim_we  = !use_g;
		upd.gsh_we  = use_g;
		upd.cho_we  = hybrid;
		upd.bim_new = train3(bim_ctr, taken);
		upd.gsh_new = train3(gsh_ctr, taken);
		upd.cho_new = cho_ctr;
		if (bok && !gok && cho_ctr != '0) upd.cho_new = cho_ctr - 1'b1;
		else if (gok && !bok && cho_ctr < CHO_MAX) upd.cho_new = cho_ctr + 1'b1;
	end

endmodule
`default_nettype wire
